FILE: hw/rtl/sbsh_pkg.sv
`timescale 1ns / 1ps

package sbsh_pkg;

    localparam int BLOCK_BITS = 512;
    localparam int WORD_BITS  = 32;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [31:0] INITIAL_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_COMP,
        ST_FINAL,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        PH_NONE,
        PH_MARK,
        PH_ZERO,
        PH_LEN,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        SEL_INPUT,
        SEL_MARK,
        SEL_ZERO,
        SEL_LEN
    } byte_sel_t;

    typedef struct packed {
        logic      byte_shift;
        byte_sel_t byte_sel;
        logic      count_byte;
        logic      load_vars;
        logic      round_en;
        logic [5:0] round_idx;
        logic      finalize;
        logic      out_shift;
        logic      msg_clear;
    } ctrl_cmd_t;

    typedef struct packed {
        logic fill_63;
        logic fill_56;
    } dp_status_t;

endpackage

FILE: hw/rtl/sha256_byte_stream_hasher.sv
`timescale 1ns / 1ps
// SHA-256 hasher for a message given as a stream of bytes.
// Input channel: in_valid/in_ready with data_byte, byte_valid and end_of_message.
// A word with byte_valid low adds no byte; end_of_message closes the message
// after the word's byte. Output channel: out_valid/out_ready, eight words per
// message, digest_word most significant first, with word_index and last_word.
// After the 64th byte of a block the input stalls while the block is compressed:
// a load step, 64 rounds of the single-round compression unit and a step to add
// into the hash. After end_of_message the padding and length bytes are shifted
// in one at a time and one or two final compressions run before the first
// digest word appears. While digest words are offered the input is not ready;
// a stalled receiver simply holds the block with the current word unchanged.
// After the eighth word is taken the block reloads the initial hash values.
// Reset (rst_n low, asynchronous) clears the hash to its initial values, the
// length and the fill level; the first word may be sent on the next cycle.
module sha256_byte_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import sbsh_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    sbsh_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .byte_valid     (byte_valid),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .word_index     (word_index),
        .last_word      (last_word),
        .status         (status),
        .cmd            (cmd)
    );

    sbsh_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (data_byte),
        .cmd         (cmd),
        .status      (status),
        .digest_word (digest_word)
    );

endmodule

FILE: hw/rtl/sbsh_datapath.sv
`timescale 1ns / 1ps

module sbsh_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          data_byte,
    input  sbsh_pkg::ctrl_cmd_t cmd,
    output sbsh_pkg::dp_status_t status,
    output logic [31:0]         digest_word
);
    import sbsh_pkg::*;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    logic [BLOCK_BITS-1:0] blk_reg;
    logic [BLOCK_BITS-1:0] blk_next;
    logic [31:0]           hash_reg [8];
    logic [31:0]           hash_next [8];
    logic [31:0]           vars_reg [8];
    logic [31:0]           vars_next [8];
    logic [63:0]           bits_reg;
    logic [63:0]           bits_next;
    logic [5:0]            fill_reg;
    logic [5:0]            fill_next;

    logic [7:0]  shift_byte;
    logic [63:0] len_shifted;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w9;
    logic [31:0] w14;
    logic [31:0] new_w;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] e_sig;
    logic [31:0] a_sig;
    logic [31:0] ch;
    logic [31:0] maj;

    assign w0  = blk_reg[BLOCK_BITS-1 -: WORD_BITS];
    assign w1  = blk_reg[BLOCK_BITS-1-WORD_BITS -: WORD_BITS];
    assign w9  = blk_reg[BLOCK_BITS-1-9*WORD_BITS -: WORD_BITS];
    assign w14 = blk_reg[BLOCK_BITS-1-14*WORD_BITS -: WORD_BITS];

    assign new_w = (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10)) + w9
                 + (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3)) + w0;

    assign e_sig = rotr(vars_reg[4], 6) ^ rotr(vars_reg[4], 11) ^ rotr(vars_reg[4], 25);
    assign a_sig = rotr(vars_reg[0], 2) ^ rotr(vars_reg[0], 13) ^ rotr(vars_reg[0], 22);
    assign ch    = (vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]);
    assign maj   = (vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
                 ^ (vars_reg[1] & vars_reg[2]);
    assign t1    = vars_reg[7] + e_sig + ch + ROUND_K[cmd.round_idx] + w0;
    assign t2    = a_sig + maj;

    // The length goes out most significant byte first as the fill runs from 56 to 63.
    assign len_shifted = bits_reg >> {~fill_reg[2:0], 3'b000};

    always_comb
    begin
        unique case (cmd.byte_sel)
            SEL_INPUT: shift_byte = data_byte;
            SEL_MARK:  shift_byte = PAD_MARK;
            SEL_ZERO:  shift_byte = 8'h00;
            SEL_LEN:   shift_byte = len_shifted[7:0];
            default:   shift_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        blk_next  = blk_reg;
        hash_next = hash_reg;
        vars_next = vars_reg;
        bits_next = bits_reg;
        fill_next = fill_reg;
        priority if (cmd.msg_clear)
        begin
            hash_next = INITIAL_HASH;
            bits_next = 64'd0;
            fill_next = 6'd0;
        end
        else if (cmd.byte_shift)
        begin
            blk_next  = {blk_reg[BLOCK_BITS-9:0], shift_byte};
            fill_next = fill_reg + 6'd1;
            if (cmd.count_byte)
            begin
                bits_next = bits_reg + 64'd8;
            end
        end
        else if (cmd.load_vars)
        begin
            vars_next = hash_reg;
        end
        else if (cmd.round_en)
        begin
            blk_next     = {blk_reg[BLOCK_BITS-WORD_BITS-1:0], new_w};
            vars_next[7] = vars_reg[6];
            vars_next[6] = vars_reg[5];
            vars_next[5] = vars_reg[4];
            vars_next[4] = vars_reg[3] + t1;
            vars_next[3] = vars_reg[2];
            vars_next[2] = vars_reg[1];
            vars_next[1] = vars_reg[0];
            vars_next[0] = t1 + t2;
        end
        else if (cmd.finalize)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_next[i] = hash_reg[i] + vars_reg[i];
            end
        end
        else if (cmd.out_shift)
        begin
            for (int i = 0; i < 7; i++)
            begin
                hash_next[i] = hash_reg[i+1];
            end
            hash_next[7] = hash_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= INITIAL_HASH;
            bits_reg <= 64'd0;
            fill_reg <= 6'd0;
        end
        else
        begin
            hash_reg <= hash_next;
            bits_reg <= bits_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg  <= blk_next;
        vars_reg <= vars_next;
    end

    assign status.fill_63 = (fill_reg == 6'd63);
    assign status.fill_56 = (fill_reg == 6'd56);
    assign digest_word    = hash_reg[0];

endmodule

FILE: hw/rtl/sbsh_ctrl.sv
`timescale 1ns / 1ps

module sbsh_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 byte_valid,
    input  logic                 end_of_message,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           word_index,
    output logic                 last_word,
    input  sbsh_pkg::dp_status_t status,
    output sbsh_pkg::ctrl_cmd_t  cmd
);
    import sbsh_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    phase_t     phase_reg;
    phase_t     phase_next;
    logic [5:0] round_reg;
    logic [5:0] round_next;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_NONE;
            round_reg <= 6'd0;
            idx_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        round_next     = round_reg;
        idx_next       = idx_reg;
        cmd.byte_shift = 1'b0;
        cmd.byte_sel   = SEL_INPUT;
        cmd.count_byte = 1'b0;
        cmd.load_vars  = 1'b0;
        cmd.round_en   = 1'b0;
        cmd.round_idx  = round_reg;
        cmd.finalize   = 1'b0;
        cmd.out_shift  = 1'b0;
        cmd.msg_clear  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (byte_valid)
                    begin
                        cmd.byte_shift = 1'b1;
                        cmd.count_byte = 1'b1;
                    end
                    if (byte_valid && status.fill_63)
                    begin
                        state_next = ST_LOAD;
                        phase_next = end_of_message ? PH_MARK : PH_NONE;
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_PAD;
                        phase_next = PH_MARK;
                    end
                end
            end
            ST_PAD:
            begin
                unique case (phase_reg)
                    PH_MARK:
                    begin
                        cmd.byte_shift = 1'b1;
                        cmd.byte_sel   = SEL_MARK;
                        phase_next     = PH_ZERO;
                        if (status.fill_63)
                        begin
                            state_next = ST_LOAD;
                        end
                    end
                    PH_ZERO:
                    begin
                        if (status.fill_56)
                        begin
                            phase_next = PH_LEN;
                        end
                        else
                        begin
                            cmd.byte_shift = 1'b1;
                            cmd.byte_sel   = SEL_ZERO;
                            if (status.fill_63)
                            begin
                                state_next = ST_LOAD;
                            end
                        end
                    end
                    PH_LEN:
                    begin
                        cmd.byte_shift = 1'b1;
                        cmd.byte_sel   = SEL_LEN;
                        if (status.fill_63)
                        begin
                            state_next = ST_LOAD;
                            phase_next = PH_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                        phase_next = PH_NONE;
                    end
                endcase
            end
            ST_LOAD:
            begin
                cmd.load_vars = 1'b1;
                round_next    = 6'd0;
                state_next    = ST_COMP;
            end
            ST_COMP:
            begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                cmd.finalize = 1'b1;
                priority if (phase_reg == PH_DONE)
                begin
                    state_next = ST_OUT;
                    idx_next   = 3'd0;
                end
                else if (phase_reg == PH_NONE)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    cmd.out_shift = 1'b1;
                    idx_next      = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        cmd.msg_clear = 1'b1;
                        state_next    = ST_IDLE;
                        phase_next    = PH_NONE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                phase_next = PH_NONE;
            end
        endcase
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = (state_reg == ST_OUT);
    assign word_index = idx_reg;
    assign last_word  = (idx_reg == 3'd7);

    a_round_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMP && round_reg == 6'd63) |=> (state_reg == ST_FINAL))
        else $error("compression did not finish after the last round");

    a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && byte_valid && status.fill_63) |=> (state_reg == ST_LOAD))
        else $error("full block did not start a compression");

    a_msg_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_word) |=> (in_ready && phase_reg == PH_NONE))
        else $error("block not ready for a new message after the digest");

    a_digest_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINAL && phase_reg == PH_DONE) |=> (out_valid && word_index == 3'd0))
        else $error("digest does not start at word zero");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int unsigned IDLE_LIMIT = 3000;
    localparam int unsigned DRAIN_CYCLES = 250;
    localparam int unsigned TARGET_ITEMS = 210;
    localparam int unsigned MAX_PRINTED = 100;
    localparam bit [7:0] PAD_BYTE = 8'h80;

    localparam bit [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam bit [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct {
        bit [31:0] word;
        bit [2:0]  index;
        bit        last;
    } digest_entry_t;

    class digest_scoreboard;
        bit [31:0]     hash_state [8];
        bit [63:0]     bit_length;
        bit [7:0]      block_buf [64];
        int unsigned   fill;
        digest_entry_t pending_digest [$];
        int unsigned   error_count;
        int unsigned   messages_closed;
        int unsigned   bytes_absorbed;
        int unsigned   extra_pad_blocks;
        int unsigned   words_checked;

        function new();
            error_count = 0;
            messages_closed = 0;
            bytes_absorbed = 0;
            extra_pad_blocks = 0;
            words_checked = 0;
            restart();
        endfunction

        function void restart();
            foreach (hash_state[i])
                hash_state[i] = SHA_IV[i];
            bit_length = '0;
            fill = 0;
        endfunction

        function bit [31:0] rotr(bit [31:0] x, int unsigned n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            bit [31:0] sched [64];
            bit [31:0] v [8];
            bit [31:0] s0;
            bit [31:0] s1;
            bit [31:0] t1;
            bit [31:0] t2;
            for (int i = 0; i < 16; i++)
                sched[i] = {block_buf[4 * i], block_buf[4 * i + 1],
                            block_buf[4 * i + 2], block_buf[4 * i + 3]};
            for (int i = 16; i < 64; i++)
            begin
                s0 = rotr(sched[i - 15], 7) ^ rotr(sched[i - 15], 18) ^ (sched[i - 15] >> 3);
                s1 = rotr(sched[i - 2], 17) ^ rotr(sched[i - 2], 19) ^ (sched[i - 2] >> 10);
                sched[i] = sched[i - 16] + s0 + sched[i - 7] + s1;
            end
            foreach (v[j])
                v[j] = hash_state[j];
            for (int i = 0; i < 64; i++)
            begin
                t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + sched[i];
                t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            foreach (v[j])
                hash_state[j] = hash_state[j] + v[j];
        endfunction

        function void absorb_word(bit [7:0] data, bit has_byte, bit closes);
            int unsigned pos;
            digest_entry_t entry;
            if (has_byte)
            begin
                block_buf[fill] = data;
                fill++;
                bit_length = bit_length + 64'd8;
                bytes_absorbed++;
                if (fill == 64)
                begin
                    compress();
                    fill = 0;
                end
            end
            if (!closes)
                return;
            block_buf[fill] = PAD_BYTE;
            pos = fill + 1;
            if (pos > 56)
            begin
                while (pos < 64)
                begin
                    block_buf[pos] = 8'h00;
                    pos++;
                end
                compress();
                pos = 0;
                extra_pad_blocks++;
            end
            while (pos < 56)
            begin
                block_buf[pos] = 8'h00;
                pos++;
            end
            for (int i = 0; i < 8; i++)
                block_buf[56 + i] = bit_length[63 - 8 * i -: 8];
            compress();
            for (int i = 0; i < 8; i++)
            begin
                entry.word = hash_state[i];
                entry.index = 3'(i);
                entry.last = (i == 7);
                pending_digest.push_back(entry);
            end
            messages_closed++;
            restart();
        endfunction

        task flag_mismatch(string what);
            error_count++;
            if (error_count <= MAX_PRINTED)
                $display("MISMATCH at %0t ns: %s", $time, what);
        endtask

        task check_digest_word(bit [31:0] word, bit [2:0] index, bit last);
            digest_entry_t want;
            if (pending_digest.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected digest word %h index %0d", word, index));
                return;
            end
            want = pending_digest.pop_front();
            words_checked++;
            if (word !== want.word)
                flag_mismatch($sformatf("digest_word %h, expected %h (index %0d)",
                                        word, want.word, want.index));
            if (index !== want.index)
                flag_mismatch($sformatf("word_index %0d, expected %0d", index, want.index));
            if (last !== want.last)
                flag_mismatch($sformatf("last_word %0b, expected %0b (index %0d)",
                                        last, want.last, want.index));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        byte_valid = 1'b0;
    logic        end_of_message = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    digest_scoreboard sb = new();

    int unsigned message_items = 0;
    int unsigned burst_left = 0;
    int unsigned stall_mode = 0;
    int unsigned stall_phase = 0;

    sha256_byte_stream_hasher DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .byte_valid     (byte_valid),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.absorb_word(data_byte, byte_valid, end_of_message);
        if (rst_n && out_valid && out_ready)
            sb.check_digest_word(digest_word, word_index, last_word);
    end

    always @(negedge clk)
    begin
        if (stall_phase == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_phase <= $urandom_range(16, 96);
        end
        else
        begin
            stall_phase <= stall_phase - 1;
        end
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            2: out_ready <= (stall_phase[1:0] == 2'd0);
            default: out_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    task automatic send_word(input logic [7:0] data, input logic has_byte, input logic closes);
        int unsigned idle_gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                burst_left = $urandom_range(60, 150);
                idle_gap = 0;
            end
            else
            begin
                burst_left = $urandom_range(1, 12);
                idle_gap = $urandom_range(1, 6);
            end
            if (idle_gap != 0)
            begin
                in_valid = 1'b0;
                repeat (idle_gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid = 1'b1;
        data_byte = data;
        byte_valid = has_byte;
        end_of_message = closes;
        do
            @(posedge clk);
        while (!in_ready);
        if (has_byte || closes)
            message_items++;
    endtask

    task automatic send_message(input int unsigned len, input bit close_on_byte);
        for (int unsigned i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_word(8'($urandom_range(0, 255)), 1'b1, close_on_byte && (i == len - 1));
        end
        if (len == 0 || !close_on_byte)
            send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    initial
    begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty messages, ignored words and extreme byte values.
        send_word(8'hff, 1'b0, 1'b1);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h5a, 1'b0, 1'b1);
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'h80, 1'b0, 1'b0);
        send_word(8'h80, 1'b1, 1'b0);
        send_word(8'h7f, 1'b1, 1'b1);

        // Lengths around the padding boundary and a whole block.
        send_message(55, 1'b1);
        send_message(56, 1'b0);
        send_message(64, 1'b0);

        while (message_items < TARGET_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
                send_message($urandom_range(50, 70), 1'($urandom_range(0, 1)));
            else
                send_message($urandom_range(0, 12), 1'($urandom_range(0, 1)));
        end

        @(negedge clk);
        in_valid = 1'b0;
        byte_valid = 1'b0;
        end_of_message = 1'b0;

        while (sb.pending_digest.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Hashed %0d messages from %0d words carrying %0d bytes.",
                 sb.messages_closed, message_items, sb.bytes_absorbed);
        $display("Padding spilled into a second block %0d times; %0d digest words checked.",
                 sb.extra_pad_blocks, sb.words_checked);
        if (sb.error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/sbsh_pkg.sv
hw/rtl/sbsh_datapath.sv
hw/rtl/sbsh_ctrl.sv
hw/rtl/sha256_byte_stream_hasher.sv
sim/tb.sv
